// ===== design/txd_pkg.sv =====
// ---------------------------------------------------------------------------
// txd_pkg: shared types and constants for the TEA/XTEA block decryptor
// Round constants, register indexes, mode codes and the queued request type.
// ---------------------------------------------------------------------------
`default_nettype none

package txd_pkg;

  // Golden-ratio round constant and its two's complement (sum step down)
  localparam logic [31:0] DELTA       = 32'h9E37_79B9;
  localparam logic [31:0] DELTA_NEG   = 32'h61C8_8647;
  // XTEA picks the first key word from sum bits 12:11
  localparam int          XTEA_KEY_SHIFT = 11;

  localparam int WORD_W   = 32;
  localparam int ROUND_W  = 5;
  localparam int CFG_IDX_W = 3;

  // Default depth of the queue between front and back
  localparam int TXD_QUEUE_DEPTH = 2;

  localparam logic [ROUND_W-1:0] ROUND_COUNT_RST = 5'd16;

  // Cipher selection codes
  localparam logic MODE_TEA  = 1'b0;
  localparam logic MODE_XTEA = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY0   = 3'd0,
    REG_KEY1   = 3'd1,
    REG_KEY2   = 3'd2,
    REG_KEY3   = 3'd3,
    REG_ROUNDS = 3'd4,
    REG_MODE   = 3'd5
  } cfg_reg_t;

  typedef logic [3:0][WORD_W-1:0] key_t;

  // One classified request as it waits for the round engine
  typedef struct packed {
    logic [WORD_W-1:0]  v0;
    logic [WORD_W-1:0]  v1;
    logic [WORD_W-1:0]  sum;
    logic [ROUND_W-1:0] rounds;
    logic               mode;
    logic               bypass;
  } txd_item_t;

  // Queue status seen by both sides
  typedef struct packed {
    logic full;
    logic empty;
  } txd_q_stat_t;

endpackage

`default_nettype wire

// ===== design/txd_in_if.sv =====
// ---------------------------------------------------------------------------
// txd_in_if: ciphertext request channel
// Valid/ready handshake carrying one 64-bit block as two big-endian words.
// ---------------------------------------------------------------------------
`default_nettype none

interface txd_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] cipher_high;
  logic [31:0] cipher_low;

  modport source (output valid, output cipher_high, output cipher_low, input ready);
  modport sink   (input valid, input cipher_high, input cipher_low, output ready);
endinterface

`default_nettype wire

// ===== design/txd_out_if.sv =====
// ---------------------------------------------------------------------------
// txd_out_if: plaintext result channel
// Valid/ready handshake carrying one decrypted 64-bit block.
// ---------------------------------------------------------------------------
`default_nettype none

interface txd_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] plain_high;
  logic [31:0] plain_low;

  modport source (output valid, output plain_high, output plain_low, input ready);
  modport sink   (input valid, input plain_high, input plain_low, output ready);
endinterface

`default_nettype wire

// ===== design/txd_front.sv =====
// ---------------------------------------------------------------------------
// txd_front: request intake
// Accepts ciphertext requests, tags them with mode, round count, start sum
// and a bypass flag for zero rounds, and hands them to the queue.
// ---------------------------------------------------------------------------
`default_nettype none

module txd_front import txd_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  txd_in_if.sink             in_blk,
  input  logic [ROUND_W-1:0] round_count,
  input  logic               cipher_mode,
  input  txd_q_stat_t        q_stat,
  output logic               q_push,
  output txd_item_t          q_item
);

  logic      stage_vld_r, stage_vld_nxt;
  txd_item_t stage_r;
  logic      accept;
  logic [ROUND_W+WORD_W-1:0] sum_full;

  // Take a new request when the holding stage is empty or drains now
  assign in_blk.ready = !stage_vld_r || !q_stat.full;
  assign accept       = in_blk.valid && in_blk.ready;
  assign q_push       = stage_vld_r && !q_stat.full;
  assign q_item       = stage_r;

  // Start sum is round_count times delta, modulo 2^32
  assign sum_full = {{WORD_W{1'b0}}, round_count} * {{ROUND_W{1'b0}}, DELTA};

  always_comb begin
    stage_vld_nxt = stage_vld_r;
    if (accept) begin
      stage_vld_nxt = 1'b1;
    end else if (q_push) begin
      stage_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stage_vld_r <= 1'b0;
    end else begin
      stage_vld_r <= stage_vld_nxt;
    end
  end

  // Classify and capture the request
  always_ff @(posedge clk) begin
    if (accept) begin
      stage_r.v0     <= in_blk.cipher_high;
      stage_r.v1     <= in_blk.cipher_low;
      stage_r.sum    <= sum_full[WORD_W-1:0];
      stage_r.rounds <= round_count;
      stage_r.mode   <= cipher_mode;
      stage_r.bypass <= (round_count == '0);
    end
  end

endmodule

`default_nettype wire

// ===== design/txd_queue.sv =====
// ---------------------------------------------------------------------------
// txd_queue: request queue between intake and round engine
// Small first-in first-out store in flip-flops with a fill count.
// ---------------------------------------------------------------------------
`default_nettype none

module txd_queue import txd_pkg::*; #(
  parameter int DEPTH = TXD_QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  input  txd_item_t   push_item,
  input  logic        pop,
  output txd_item_t   head_item,
  output txd_q_stat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  txd_item_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_FULL);
  assign stat.empty = (cnt_r == '0);
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_item  = slot_r[rd_ptr_r];

  // Advance pointers with wrap, track fill level
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_LAST) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_LAST) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

// ===== design/txd_engine.sv =====
// ---------------------------------------------------------------------------
// txd_engine: round engine and result register
// Pops one request, runs one TEA or XTEA decryption round per cycle, then
// places the block in the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module txd_engine import txd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  key_t        key,
  input  txd_item_t   head_item,
  input  txd_q_stat_t q_stat,
  output logic        q_pop,
  txd_out_if.source   out_blk
);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } eng_state_t;

  eng_state_t         state_r, state_nxt;
  logic [WORD_W-1:0]  v0_r, v1_r, sum_r;
  logic [ROUND_W-1:0] cnt_r;
  logic               mode_r;
  logic               out_vld_r, out_vld_nxt;
  logic [WORD_W-1:0]  plain_high_r, plain_low_r;
  logic               emit;

  logic [WORD_W-1:0]  sum_dn;
  logic [WORD_W-1:0]  tea_t1, tea_v1, tea_t0, tea_v0;
  logic [WORD_W-1:0]  xt_t1, xt_v1, xt_t0, xt_v0;
  logic [WORD_W-1:0]  v0_rnd, v1_rnd;

  // One decryption round of each cipher
  always_comb begin
    sum_dn = sum_r + DELTA_NEG;

    tea_t1 = ((v0_r << 4) + key[2]) ^ ((v0_r >> 5) + key[3]) ^ (sum_r + v0_r);
    tea_v1 = v1_r - tea_t1;
    tea_t0 = ((tea_v1 << 4) + key[0]) ^ ((tea_v1 >> 5) + key[1]) ^ (sum_r + tea_v1);
    tea_v0 = v0_r - tea_t0;

    xt_t1 = (((v0_r << 4) ^ (v0_r >> 5)) + v0_r)
            ^ (sum_r + key[sum_r[XTEA_KEY_SHIFT +: 2]]);
    xt_v1 = v1_r - xt_t1;
    xt_t0 = (((xt_v1 << 4) ^ (xt_v1 >> 5)) + xt_v1) ^ (sum_dn + key[sum_dn[1:0]]);
    xt_v0 = v0_r - xt_t0;

    v0_rnd = (mode_r == MODE_XTEA) ? xt_v0 : tea_v0;
    v1_rnd = (mode_r == MODE_XTEA) ? xt_v1 : tea_v1;
  end

  assign q_pop = (state_r == ST_IDLE) && !q_stat.empty;
  assign emit  = (state_r == ST_HOLD) && (!out_vld_r || out_blk.ready);

  // Sequence: load, iterate rounds, hand over to the output register
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (q_pop) begin
          state_nxt = head_item.bypass ? ST_HOLD : ST_RUN;
        end
      end
      ST_RUN: begin
        if (cnt_r == ROUND_W'(1)) begin
          state_nxt = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (emit) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_vld_nxt = out_vld_r;
    if (emit) begin
      out_vld_nxt = 1'b1;
    end else if (out_blk.ready) begin
      out_vld_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // Working block, sum and round counter
  always_ff @(posedge clk) begin
    if (q_pop) begin
      v0_r   <= head_item.v0;
      v1_r   <= head_item.v1;
      sum_r  <= head_item.sum;
      cnt_r  <= head_item.rounds;
      mode_r <= head_item.mode;
    end else if (state_r == ST_RUN) begin
      v0_r  <= v0_rnd;
      v1_r  <= v1_rnd;
      sum_r <= sum_dn;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Result register, held while the receiver stalls
  always_ff @(posedge clk) begin
    if (emit) begin
      plain_high_r <= v0_r;
      plain_low_r  <= v1_r;
    end
  end

  assign out_blk.valid      = out_vld_r;
  assign out_blk.plain_high = plain_high_r;
  assign out_blk.plain_low  = plain_low_r;

endmodule

`default_nettype wire

// ===== design/tea_xtea_block_decrypt.sv =====
// ---------------------------------------------------------------------------
// tea_xtea_block_decrypt: TEA / XTEA ECB block decryptor
//
// in_blk carries one ciphertext request (cipher_high, cipher_low) under a
// valid/ready handshake; out_blk returns one plaintext block per request in
// the same order. cfg_we/cfg_index/cfg_wdata write the key words, the round
// count and the cipher mode; write them only while no request is in flight.
//
// Path: an intake stage and the queue, then the round engine loads the
// block, runs its rounds and hands it over to the output register. A round
// count of zero passes the block through in the same path.
// The single round unit works on one block at a time and pops the next one
// only after handing the last one over; requests keep arriving into the
// queue while it works.
// Reset (synchronous, rst_n low) empties intake, queue and output register,
// clears the key to zero, sets 16 rounds and TEA mode.
// When the receiver stalls the result holds in the output register, the
// engine waits with its finished block, and intake and queue fill up before
// in_blk.ready falls.
// ---------------------------------------------------------------------------
`default_nettype none

module tea_xtea_block_decrypt import txd_pkg::*; #(
  parameter int QUEUE_DEPTH = TXD_QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [WORD_W-1:0]    cfg_wdata,
  txd_in_if.sink               in_blk,
  txd_out_if.source            out_blk
);

  key_t               key_r;
  logic [ROUND_W-1:0] round_count_r;
  logic               cipher_mode_r;

  txd_q_stat_t q_stat;
  logic        q_push, q_pop;
  txd_item_t   q_in_item, q_head_item;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r         <= '0;
      round_count_r <= ROUND_COUNT_RST;
      cipher_mode_r <= MODE_TEA;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_KEY0:   key_r[0]      <= cfg_wdata;
        REG_KEY1:   key_r[1]      <= cfg_wdata;
        REG_KEY2:   key_r[2]      <= cfg_wdata;
        REG_KEY3:   key_r[3]      <= cfg_wdata;
        REG_ROUNDS: round_count_r <= cfg_wdata[ROUND_W-1:0];
        REG_MODE:   cipher_mode_r <= cfg_wdata[0];
        default:    ;
      endcase
    end
  end

  txd_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_blk      (in_blk),
    .round_count (round_count_r),
    .cipher_mode (cipher_mode_r),
    .q_stat      (q_stat),
    .q_push      (q_push),
    .q_item      (q_in_item)
  );

  txd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_item (q_in_item),
    .pop       (q_pop),
    .head_item (q_head_item),
    .stat      (q_stat)
  );

  txd_engine u_engine (
    .clk       (clk),
    .rst_n     (rst_n),
    .key       (key_r),
    .head_item (q_head_item),
    .q_stat    (q_stat),
    .q_pop     (q_pop),
    .out_blk   (out_blk)
  );

endmodule

`default_nettype wire

// ===== design/txd_checker.sv =====
// ---------------------------------------------------------------------------
// txd_checker: port-level checks for the block decryptor
// Tracks requests in flight from the handshakes and checks the output register
// behaviour, and that results and intake stalls occur only with requests pending.
// ---------------------------------------------------------------------------
`default_nettype none

module txd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] plain_high,
  input logic [31:0] plain_low
);

  logic [7:0] inflight_r;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // Count requests accepted but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      inflight_r <= '0;
    end else begin
      inflight_r <= inflight_r + {7'd0, in_acc} - {7'd0, out_acc};
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(plain_high) && $stable(plain_low))
    else $error("result changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> inflight_r != 8'd0)
    else $error("result without a pending request");

  a_ready_busy: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> inflight_r != 8'd0)
    else $error("intake stalled while empty");

endmodule

bind tea_xtea_block_decrypt txd_checker u_txd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_blk.valid),
  .in_ready   (in_blk.ready),
  .out_valid  (out_blk.valid),
  .out_ready  (out_blk.ready),
  .plain_high (out_blk.plain_high),
  .plain_low  (out_blk.plain_low)
);

`default_nettype wire

// ===== tb/sv/tea_xtea_block_decrypt_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tea_xtea_block_decrypt_tb: self-checking bench for the TEA/XTEA decryptor
// A directed table of blocks runs first under several key, round and mode
// settings. Random phases follow, each with fresh register values. Every
// accepted request is decrypted by a local predictor unless the table gives
// its plaintext; returned blocks are compared in order. Both sides idle at
// random, and one phase holds the receiver off long enough to back up the input.
// ---------------------------------------------------------------------------

module tea_xtea_block_decrypt_tb;
  import txd_pkg::*;

  localparam int CLK_HALF      = 2;
  localparam int RST_CYCLES    = 8;
  localparam int SETTLE_CYCLES = 40;    // margin for the slowest block, with 31 rounds
  localparam int STALL_LIMIT   = 4000;  // cycles with no handshake at all
  localparam int HOLD_CYCLES   = 300;
  localparam int NUM_PHASES    = 10;
  localparam int PHASE_ITEMS   = 55;
  localparam int NUM_DIRECTED  = 20;
  localparam int PRINT_LIMIT   = 50;

  // Indexes beyond the register file; writes there must change nothing
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  localparam logic [ROUND_W-1:0] ROUNDS_NONE = '0;
  localparam logic [ROUND_W-1:0] ROUNDS_ONE  = 5'd1;
  localparam logic [ROUND_W-1:0] ROUNDS_HALF = 5'd8;
  localparam logic [ROUND_W-1:0] ROUNDS_MAX  = '1;

  // Key words listed as {k3, k2, k1, k0}
  localparam key_t KEY_ZERO = '0;
  localparam key_t KEY_ONES = '1;
  localparam key_t KEY_MIX  = {32'h0F1E_2D3C, 32'h4B5A_6978, 32'h8796_A5B4, 32'hC3D2_E1F0};
  localparam key_t KEY_ALT  = {32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000};

  typedef struct packed {
    logic [WORD_W-1:0] hi;
    logic [WORD_W-1:0] lo;
  } blk_t;

  typedef struct packed {
    logic known;
    blk_t plain;
  } known_plain_t;

  typedef struct packed {
    key_t               key;
    logic [ROUND_W-1:0] rounds;
    logic               mode;
    blk_t               cipher;
    logic               known;
    blk_t               plain;
  } vector_t;

  // Plaintext is typed in only for the zero-round pass-through rows
  vector_t directed_vectors [NUM_DIRECTED] = '{
    '{KEY_ZERO, ROUND_COUNT_RST, MODE_TEA,  {32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
    '{KEY_ZERO, ROUND_COUNT_RST, MODE_TEA,  {32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{KEY_ZERO, ROUND_COUNT_RST, MODE_TEA,  {32'h8000_0000, 32'h0000_0001}, 1'b0, '0},
    '{KEY_MIX,  ROUNDS_NONE,     MODE_TEA,  {32'h0000_0000, 32'h0000_0000}, 1'b1,
      {32'h0000_0000, 32'h0000_0000}},
    '{KEY_MIX,  ROUNDS_NONE,     MODE_TEA,  {32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
      {32'hFFFF_FFFF, 32'hFFFF_FFFF}},
    '{KEY_MIX,  ROUNDS_NONE,     MODE_TEA,  {32'h0123_4567, 32'h89AB_CDEF}, 1'b1,
      {32'h0123_4567, 32'h89AB_CDEF}},
    '{KEY_MIX,  ROUNDS_NONE,     MODE_XTEA, {32'hFEDC_BA98, 32'h7654_3210}, 1'b1,
      {32'hFEDC_BA98, 32'h7654_3210}},
    '{KEY_MIX,  ROUNDS_NONE,     MODE_XTEA, {32'hFFFF_FFFF, 32'h0000_0000}, 1'b1,
      {32'hFFFF_FFFF, 32'h0000_0000}},
    '{KEY_MIX,  ROUNDS_ONE,      MODE_TEA,  {32'h0123_4567, 32'h89AB_CDEF}, 1'b0, '0},
    '{KEY_MIX,  ROUNDS_ONE,      MODE_XTEA, {32'h0123_4567, 32'h89AB_CDEF}, 1'b0, '0},
    '{KEY_ONES, ROUNDS_MAX,      MODE_TEA,  {32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
    '{KEY_ONES, ROUNDS_MAX,      MODE_TEA,  {32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{KEY_ONES, ROUNDS_MAX,      MODE_XTEA, {32'h0000_0000, 32'h0000_0000}, 1'b0, '0},
    '{KEY_ONES, ROUNDS_MAX,      MODE_XTEA, {32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b0, '0},
    '{KEY_MIX,  ROUND_COUNT_RST, MODE_XTEA, {32'hDEAD_BEEF, 32'h0BAD_F00D}, 1'b0, '0},
    '{KEY_MIX,  ROUNDS_HALF,     MODE_XTEA, {32'hAAAA_AAAA, 32'h5555_5555}, 1'b0, '0},
    '{KEY_MIX,  ROUNDS_HALF,     MODE_TEA,  {32'h5555_5555, 32'hAAAA_AAAA}, 1'b0, '0},
    '{KEY_ALT,  ROUNDS_MAX,      MODE_XTEA, {32'h1234_5678, 32'h9ABC_DEF0}, 1'b0, '0},
    '{KEY_ALT,  ROUNDS_MAX,      MODE_TEA,  {32'h1234_5678, 32'h9ABC_DEF0}, 1'b0, '0},
    '{KEY_ZERO, ROUNDS_NONE,     MODE_TEA,  {32'h7FFF_FFFF, 32'h8000_0000}, 1'b1,
      {32'h7FFF_FFFF, 32'h8000_0000}}
  };

  logic clk;
  logic rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [WORD_W-1:0]    cfg_wdata;

  txd_in_if  in_blk_if ();
  txd_out_if out_blk_if ();

  // Local copy of the register file
  key_t               key_reg;
  logic [ROUND_W-1:0] rounds_reg;
  logic               mode_reg;

  blk_t         plain_q [$];
  known_plain_t known_q [$];

  int errors;
  int stall_cnt;
  bit quiet;
  bit hold_req;

  tea_xtea_block_decrypt u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_blk    (in_blk_if),
    .out_blk   (out_blk_if)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // Decrypt one block under the current key, round count and mode
  function automatic blk_t decrypt_block(input blk_t cipher);
    logic [WORD_W-1:0] v0;
    logic [WORD_W-1:0] v1;
    logic [WORD_W-1:0] total;
    blk_t plain;
    v0    = cipher.hi;
    v1    = cipher.lo;
    total = DELTA * WORD_W'(rounds_reg);
    for (int r = 0; r < int'(rounds_reg); r++) begin
      if (mode_reg == MODE_TEA) begin
        v1 = v1 - (((v0 << 4) + key_reg[2]) ^ ((v0 >> 5) + key_reg[3]) ^ (total + v0));
        v0 = v0 - (((v1 << 4) + key_reg[0]) ^ ((v1 >> 5) + key_reg[1]) ^ (total + v1));
        total = total - DELTA;
      end else begin
        v1 = v1 - ((((v0 << 4) ^ (v0 >> 5)) + v0) ^ (total + key_reg[total[12:11]]));
        total = total - DELTA;
        v0 = v0 - ((((v1 << 4) ^ (v1 >> 5)) + v1) ^ (total + key_reg[total[1:0]]));
      end
    end
    plain.hi = v0;
    plain.lo = v1;
    return plain;
  endfunction

  // Mostly random words, with the extremes turning up often
  function automatic logic [WORD_W-1:0] rand_word();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      2:       return 32'h8000_0000;
      3:       return 32'h0000_0001;
      default: return $urandom();
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (errors < PRINT_LIMIT) $display("%0t ns mismatch: %s", $time, what);
    errors++;
  endtask

  // Write one register and track it in the local copy
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [WORD_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_KEY0, REG_KEY1, REG_KEY2, REG_KEY3: key_reg[idx[1:0]] = data;
      REG_ROUNDS: rounds_reg = data[ROUND_W-1:0];
      REG_MODE:   mode_reg   = data[0];
      default: ;
    endcase
  endtask

  // Upper bits of the narrow registers carry noise that must be dropped
  task automatic apply_config(input key_t k, input logic [ROUND_W-1:0] r, input logic m,
                              input bit all_regs);
    for (int w = 0; w < 4; w++)
      if (all_regs || k[w] != key_reg[w])
        write_reg(CFG_IDX_W'(int'(REG_KEY0) + w), k[w]);
    if (all_regs || r != rounds_reg)
      write_reg(REG_ROUNDS, (WORD_W'($urandom()) << ROUND_W) | WORD_W'(r));
    if (all_regs || m != mode_reg)
      write_reg(REG_MODE, (WORD_W'($urandom()) << 1) | WORD_W'(m));
  endtask

  // Offer one request, after an optional gap, and hold it until taken
  task automatic send_block(input blk_t cipher, input logic known, input blk_t plain);
    int gap;
    known_plain_t tag;
    gap = (!quiet && $urandom_range(99, 0) < 25) ? $urandom_range(8, 1) : 0;
    tag.known = known;
    tag.plain = plain;
    @(negedge clk);
    if (gap > 0) begin
      in_blk_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    known_q.push_back(tag);
    in_blk_if.valid       <= 1'b1;
    in_blk_if.cipher_high <= cipher.hi;
    in_blk_if.cipher_low  <= cipher.lo;
    do @(posedge clk); while (!in_blk_if.ready);
  endtask

  // Drop valid, wait for every block to return, then let the engine go idle
  task automatic drain_and_settle();
    @(negedge clk);
    in_blk_if.valid <= 1'b0;
    while (plain_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Receiver: random stalls, quiet stretches and one long hold-off
  initial begin : result_sink
    int hold_left;
    hold_left = 0;
    out_blk_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        hold_left--;
        out_blk_if.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req = 1'b0;
        hold_left = HOLD_CYCLES;
        out_blk_if.ready <= 1'b0;
      end else begin
        out_blk_if.ready <= quiet || ($urandom_range(99, 0) >= 25);
      end
    end
  end

  // Predict on each accepted request; compare each returned block
  always @(posedge clk) begin : plain_check
    known_plain_t tag;
    blk_t cipher;
    blk_t want;
    if (rst_n && in_blk_if.valid && in_blk_if.ready) begin
      tag       = known_q.pop_front();
      cipher.hi = in_blk_if.cipher_high;
      cipher.lo = in_blk_if.cipher_low;
      plain_q.push_back(tag.known ? tag.plain : decrypt_block(cipher));
    end
    if (rst_n && out_blk_if.valid && out_blk_if.ready) begin
      if (plain_q.size() == 0) begin
        report_mismatch($sformatf("unexpected block %h %h",
                                  out_blk_if.plain_high, out_blk_if.plain_low));
      end else begin
        want = plain_q.pop_front();
        if (out_blk_if.plain_high !== want.hi)
          report_mismatch($sformatf("plain_high got %h want %h",
                                    out_blk_if.plain_high, want.hi));
        if (out_blk_if.plain_low !== want.lo)
          report_mismatch($sformatf("plain_low got %h want %h",
                                    out_blk_if.plain_low, want.lo));
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_blk_if.valid && in_blk_if.ready) ||
        (out_blk_if.valid && out_blk_if.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin : stimulus
    key_t               new_key;
    logic [ROUND_W-1:0] new_rounds;
    logic               new_mode;
    blk_t               cipher;

    rst_n                 = 1'b0;
    cfg_we                = 1'b0;
    cfg_index             = REG_KEY0;
    cfg_wdata             = '0;
    in_blk_if.valid       = 1'b0;
    in_blk_if.cipher_high = '0;
    in_blk_if.cipher_low  = '0;
    key_reg               = KEY_ZERO;
    rounds_reg            = ROUND_COUNT_RST;
    mode_reg              = MODE_TEA;

    repeat (RST_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed table; reconfigure only when a row asks for new settings
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      if (directed_vectors[i].key != key_reg || directed_vectors[i].rounds != rounds_reg ||
          directed_vectors[i].mode != mode_reg) begin
        drain_and_settle();
        apply_config(directed_vectors[i].key, directed_vectors[i].rounds,
                     directed_vectors[i].mode, 1'b0);
      end
      send_block(directed_vectors[i].cipher, directed_vectors[i].known,
                 directed_vectors[i].plain);
    end

    // Random phases, each under a fresh register setting
    for (int p = 0; p < NUM_PHASES; p++) begin
      drain_and_settle();
      quiet = 1'b0;
      for (int w = 0; w < 4; w++) new_key[w] = rand_word();
      new_rounds = (p == 0) ? ROUNDS_NONE :
                   (p == 1) ? ROUNDS_MAX  : ROUND_W'($urandom_range(31, 0));
      new_mode   = (p < 4) ? p[0] : 1'($urandom_range(1, 0));
      write_reg($urandom_range(1, 0) ? REG_SPARE_HI : REG_SPARE_LO, $urandom());
      apply_config(new_key, new_rounds, new_mode, 1'b1);
      quiet    = (p == 3);
      hold_req = (p == 5);
      repeat (PHASE_ITEMS) begin
        cipher.hi = rand_word();
        cipher.lo = rand_word();
        send_block(cipher, 1'b0, '0);
      end
    end

    drain_and_settle();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
